[design/assert_macros.svh]
// Assertion macros used by the top level of the blend unit.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checks a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");
// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[design/abu_pkg.sv]
// Shared types and constants of the alpha blend unit.
// No dependencies; used by every module of the block.
package abu_pkg;

	localparam int ChanW   = 8;
	localparam int NumChan = 4;
	localparam int ColorW  = ChanW * NumChan;
	localparam int InstrW  = 3;
	localparam int IdxW    = 3;
	localparam int CfgW    = 8;
	localparam logic [ChanW-1:0] ChanMax = 8'd255;

	// Register indices of the configuration port.
	typedef enum logic [IdxW-1:0] {
		REG_SRC_FROM_SEC = 3'd0,
		REG_DST_IS_SEC   = 3'd1,
		REG_SRC_INSTR    = 3'd2,
		REG_DST_INSTR    = 3'd3,
		REG_ATEST_ON     = 3'd4,
		REG_ALPHA_REF    = 3'd5
	} reg_idx_t;

	// Factor source selected by bits 2:1 of a factor instruction.
	typedef enum logic [1:0] {
		FSEL_ZERO      = 2'd0,
		FSEL_OTHER     = 2'd1,
		FSEL_SRC_ALPHA = 2'd2,
		FSEL_DST_ALPHA = 2'd3
	} fsel_t;

	typedef struct packed {
		logic              src_from_secondary;
		logic              dst_is_secondary;
		logic [InstrW-1:0] src_factor_instr;
		logic [InstrW-1:0] dst_factor_instr;
		logic              alpha_test_on;
		logic [ChanW-1:0]  alpha_reference;
	} cfg_t;

endpackage

[design/abu_cfg_regs.sv]
// Configuration register file of the alpha blend unit.
// Depends on abu_pkg for the register indices and the cfg_t struct.
module abu_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [abu_pkg::IdxW-1:0]    cfg_index,
	input  logic [abu_pkg::CfgW-1:0]    cfg_data,
	output abu_pkg::cfg_t               cfg
);

	abu_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			// Indices beyond the list are ignored; wide data keeps its low bits.
			unique case (cfg_index)
				abu_pkg::REG_SRC_FROM_SEC: begin
					cfg_q.src_from_secondary <= cfg_data[0];
				end
				abu_pkg::REG_DST_IS_SEC: begin
					cfg_q.dst_is_secondary <= cfg_data[0];
				end
				abu_pkg::REG_SRC_INSTR: begin
					cfg_q.src_factor_instr <= cfg_data[abu_pkg::InstrW-1:0];
				end
				abu_pkg::REG_DST_INSTR: begin
					cfg_q.dst_factor_instr <= cfg_data[abu_pkg::InstrW-1:0];
				end
				abu_pkg::REG_ATEST_ON: begin
					cfg_q.alpha_test_on <= cfg_data[0];
				end
				abu_pkg::REG_ALPHA_REF: begin
					cfg_q.alpha_reference <= cfg_data[abu_pkg::ChanW-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[design/abu_chan_blend.sv]
// One colour channel of the blend: factor selection, two 8x8 products,
// sum, shift and saturation. Depends on abu_pkg.
module abu_chan_blend (
	input  logic [abu_pkg::InstrW-1:0] src_instr,
	input  logic [abu_pkg::InstrW-1:0] dst_instr,
	input  logic [abu_pkg::ChanW-1:0]  src_c,
	input  logic [abu_pkg::ChanW-1:0]  dst_c,
	input  logic [abu_pkg::ChanW-1:0]  src_a,
	input  logic [abu_pkg::ChanW-1:0]  dst_a,
	output logic [abu_pkg::ChanW-1:0]  res
);

	localparam int ProdW = 2 * abu_pkg::ChanW;

	function automatic logic [abu_pkg::ChanW-1:0] pick_factor(
		input logic [abu_pkg::InstrW-1:0] instr,
		input logic [abu_pkg::ChanW-1:0]  other,
		input logic [abu_pkg::ChanW-1:0]  sa,
		input logic [abu_pkg::ChanW-1:0]  da
	);
		logic [abu_pkg::ChanW-1:0] f;
		unique case (abu_pkg::fsel_t'(instr[2:1]))
			abu_pkg::FSEL_ZERO:      f = '0;
			abu_pkg::FSEL_OTHER:     f = other;
			abu_pkg::FSEL_SRC_ALPHA: f = sa;
			abu_pkg::FSEL_DST_ALPHA: f = da;
			default:                 f = '0;
		endcase
		// The invert bit turns f into 255 - f, which is the bitwise complement.
		return instr[0] ? ~f : f;
	endfunction

	logic [abu_pkg::ChanW-1:0] sf, df;
	logic [ProdW-1:0]          src_prod, dst_prod;
	logic [ProdW:0]            sum;
	logic [ProdW-abu_pkg::ChanW:0] shifted;

	always_comb begin
		sf       = pick_factor(src_instr, dst_c, src_a, dst_a);
		df       = pick_factor(dst_instr, src_c, src_a, dst_a);
		src_prod = src_c * sf;
		dst_prod = dst_c * df;
		sum      = {1'b0, src_prod} + {1'b0, dst_prod};
		shifted  = sum[ProdW:abu_pkg::ChanW];
		// Only the top bit can exceed a byte after the shift.
		res      = shifted[ProdW-abu_pkg::ChanW] ? abu_pkg::ChanMax
		                                         : shifted[abu_pkg::ChanW-1:0];
	end

endmodule

[design/alpha_blend_unit.sv]
// Top level of the alpha blend unit: configuration registers, input stage,
// four channel blenders and the result stage. Depends on abu_pkg,
// abu_cfg_regs, abu_chan_blend and assert_macros.svh.
//
// Usage
// The input channel (in_valid/in_ready) carries one pixel request: the shaded
// colour and the primary and secondary accumulator colours, all packed BGRA.
// The output channel (out_valid/out_ready) returns one result per request:
// the blended colour, the write enable from the alpha test and the target
// buffer. Requests leave in the order they arrived.
// The block is a two-stage pipeline. Stage one registers the selected source
// and destination colours, the alpha test outcome and the target buffer; the
// four channel blenders then work between stage one and the result register.
// A request in stage one moves to the result register when that can load, and
// one request is taken every cycle while the receiver keeps out_ready high;
// the two 8x8 multiplies and each channel's add fit between the two registers.
// When the receiver stalls, the result register holds its value, stage one
// still fills, and in_ready falls only once both stages are full.
// Configuration writes (cfg_we/cfg_index/cfg_data) act on the next edge; the user
// must make them only while the pipeline is empty; the block does not enforce it.
// Reset (arst_n low) clears both valid flags and all configuration registers.
`include "assert_macros.svh"

module alpha_blend_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration port
	input  logic                          cfg_we,
	input  logic [abu_pkg::IdxW-1:0]      cfg_index,
	input  logic [abu_pkg::CfgW-1:0]      cfg_data,
	// request channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [abu_pkg::ColorW-1:0]    shaded_color,
	input  logic [abu_pkg::ColorW-1:0]    primary_accum,
	input  logic [abu_pkg::ColorW-1:0]    secondary_accum,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [abu_pkg::ColorW-1:0]    blended_color,
	output logic                          write_enable,
	output logic                          write_to_secondary
);

	localparam int CW = abu_pkg::ChanW;

	abu_pkg::cfg_t cfg;

	// Stage one holds the operands, stage two the finished result.
	logic                       vld_s1, vld_s2;
	logic [abu_pkg::ColorW-1:0] src_s1, dst_s1;
	logic                       we_s1, to_sec_s1;
	logic [abu_pkg::ColorW-1:0] color_s2;
	logic                       we_s2, to_sec_s2;

	logic                       adv_s1, adv_s2;
	logic [abu_pkg::ColorW-1:0] src_sel, dst_sel, blend;
	logic                       we_sel;

	abu_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The result register loads whenever it is empty or being drained, and
	// stage one loads whenever its contents can move on.
	assign adv_s2   = !vld_s2 || out_ready;
	assign adv_s1   = !vld_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_comb begin
		src_sel = cfg.src_from_secondary ? secondary_accum : shaded_color;
		dst_sel = cfg.dst_is_secondary ? secondary_accum : primary_accum;
		// The alpha test compares the source alpha against the reference.
		we_sel  = !cfg.alpha_test_on ||
		          (src_sel[abu_pkg::ColorW-1 -: CW] >= cfg.alpha_reference);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				vld_s1 <= in_valid;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			src_s1    <= src_sel;
			dst_s1    <= dst_sel;
			we_s1     <= we_sel;
			to_sec_s1 <= cfg.dst_is_secondary;
		end
		if (adv_s2 && vld_s1) begin
			color_s2  <= blend;
			we_s2     <= we_s1;
			to_sec_s2 <= to_sec_s1;
		end
	end

	for (genvar i = 0; i < abu_pkg::NumChan; i++) begin : g_chan
		abu_chan_blend u_chan (
			.src_instr (cfg.src_factor_instr),
			.dst_instr (cfg.dst_factor_instr),
			.src_c     (src_s1[i*CW +: CW]),
			.dst_c     (dst_s1[i*CW +: CW]),
			.src_a     (src_s1[abu_pkg::ColorW-1 -: CW]),
			.dst_a     (dst_s1[abu_pkg::ColorW-1 -: CW]),
			.res       (blend[i*CW +: CW])
		);
	end

	assign out_valid          = vld_s2;
	assign blended_color      = color_s2;
	assign write_enable       = we_s2;
	assign write_to_secondary = to_sec_s2;

	// An empty result register never blocks new requests.
	`ASSERT_ALWAYS(a_ready_when_empty, clk, arst_n, out_valid || in_ready)
	// A request held in stage one while the result is stalled keeps its operands.
	`ASSERT_NEXT(a_s1_hold, clk, arst_n, vld_s1 && !adv_s2, vld_s1 && $stable(src_s1) && $stable(dst_s1))
	// A request in stage one that can advance becomes a result next cycle.
	`ASSERT_NEXT(a_s1_to_out, clk, arst_n, vld_s1 && adv_s2, out_valid)
	// With the alpha test off every accepted request is marked for writing.
	`ASSERT_NEXT(a_we_atest_off, clk, arst_n, in_valid && in_ready && !cfg.alpha_test_on, we_s1)

endmodule
